/* hdl/bdq_pkg.sv */
package bdq_pkg;

   localparam int DEPTH_DEF = 1024;
   localparam int DATA_W    = 32;
   localparam int KIND_W    = 3;
   localparam int CAP_W     = 11;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_STATUS     = 3'd4;

   typedef struct packed {
      logic take;   // request accepted this cycle
      logic exec;   // update pointers and store
      logic rd;     // read front and rear entries
   } cmd_type;

endpackage

/* hdl/bdq_ctrl.sv */
module bdq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_strobe,
   output bdq_pkg::cmd_type cmd
);
   import bdq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_RESP
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      exec_ff;
   logic      rd_ff;
   logic      strobe_ff;
   logic      take;

   assign take = start & ~busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         exec_ff   <= 1'b0;
         rd_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         exec_ff   <= 1'b0;
         rd_ff     <= 1'b0;
         strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE, ST_RESP: begin
               if (take) begin
                  state_ff <= ST_EXEC;
                  busy_ff  <= 1'b1;
                  exec_ff  <= 1'b1;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_EXEC: begin
               state_ff <= ST_READ;
               rd_ff    <= 1'b1;
            end
            ST_READ: begin
               state_ff  <= ST_RESP;
               busy_ff   <= 1'b0;
               strobe_ff <= 1'b1;
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;
   assign cmd.take   = take;
   assign cmd.exec   = exec_ff;
   assign cmd.rd     = rd_ff;

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take, cmd.exec, cmd.rd, rsp_strobe}) || (cmd.take && rsp_strobe))
      else $error("controller commands overlap");

   a_take_then_exec: assert property (@(posedge clock) disable iff (reset)
      !reset && cmd.take |=> cmd.exec && busy)
      else $error("accepted request not executed");

   a_strobe_after_read: assert property (@(posedge clock) disable iff (reset)
      !reset && cmd.rd |=> rsp_strobe && !busy)
      else $error("response not issued after read");

endmodule

/* hdl/bdq_dpath.sv */
module bdq_dpath #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bdq_pkg::cmd_type                    cmd,
   input  logic [bdq_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [bdq_pkg::DATA_W-1:0]   req_value,
   input  logic                                csr_we,
   input  logic [bdq_pkg::CAP_W-1:0]           csr_wdata,
   output logic                                rsp_ok,
   output logic signed [bdq_pkg::DATA_W-1:0]   rsp_front_value,
   output logic signed [bdq_pkg::DATA_W-1:0]   rsp_rear_value,
   output logic                                rsp_is_empty,
   output logic                                rsp_is_full,
   output logic [bdq_pkg::CAP_W-1:0]           rsp_occupancy
);
   import bdq_pkg::*;

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int SW   = AW + 1;
   localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

   localparam logic [AW-1:0]   LAST_IDX = AW'(DEPTH - 1);
   localparam logic [SW-1:0]   DEPTH_S  = SW'(DEPTH);
   localparam logic [CMPW-1:0] DEPTH_C  = CMPW'(DEPTH);

   logic [DATA_W-1:0] mem [0:DEPTH-1];

   logic [CAP_W-1:0]  cap_ff;
   logic [AW-1:0]     front_ff, front_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              ok_ff, ok_in;
   logic [KIND_W-1:0] kind_ff;
   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] rd_front_ff;
   logic [DATA_W-1:0] rd_rear_ff;

   logic [CMPW-1:0]   cap_c;
   logic [CMPW-1:0]   eff_cap;
   logic [CMPW-1:0]   count_c;
   logic              full;
   logic              empty;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     prev_idx;
   logic [AW-1:0]     rear_addr;

   function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] p,
                                              input logic [CW-1:0] n);
      logic [SW-1:0] s;
      s = SW'(p) + SW'(n);
      if (s >= DEPTH_S) begin
         s = s - DEPTH_S;
      end
      return s[AW-1:0];
   endfunction

   assign cap_c   = CMPW'(cap_ff);
   assign eff_cap = (cap_c > DEPTH_C) ? DEPTH_C : cap_c;
   assign count_c = CMPW'(count_ff);
   assign full    = count_c >= eff_cap;
   assign empty   = (count_ff == '0);
   assign prev_idx = (front_ff == '0) ? LAST_IDX : front_ff - AW'(1);

   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      ok_in    = 1'b1;
      wr_en    = 1'b0;
      wr_addr  = prev_idx;
      case (kind_ff)
         KIND_PUSH_FRONT: begin
            if (full) begin
               ok_in = 1'b0;
            end else begin
               front_in = prev_idx;
               wr_en    = 1'b1;
               wr_addr  = prev_idx;
               count_in = count_ff + CW'(1);
            end
         end
         KIND_PUSH_BACK: begin
            if (full) begin
               ok_in = 1'b0;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = ring_add(front_ff, count_ff);
               count_in = count_ff + CW'(1);
            end
         end
         KIND_POP_FRONT: begin
            if (empty) begin
               ok_in = 1'b0;
            end else begin
               front_in = ring_add(front_ff, CW'(1));
               count_in = count_ff - CW'(1);
            end
         end
         KIND_POP_BACK: begin
            if (empty) begin
               ok_in = 1'b0;
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         default: begin
            ok_in = 1'b1;
         end
      endcase
   end

   // rear sits one below front plus count; unused when empty
   assign rear_addr = empty ? front_ff : ring_add(front_ff, count_ff - CW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         front_ff <= '0;
         count_ff <= '0;
         ok_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         if (cmd.exec) begin
            front_ff <= front_in;
            count_ff <= count_in;
            ok_ff    <= ok_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         kind_ff  <= req_kind;
         value_ff <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         mem[wr_addr] <= value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_front_ff <= mem[front_ff];
         rd_rear_ff  <= mem[rear_addr];
      end
   end

   assign rsp_ok          = ok_ff;
   assign rsp_front_value = empty ? '1 : rd_front_ff;
   assign rsp_rear_value  = empty ? '1 : rd_rear_ff;
   assign rsp_is_empty    = empty;
   assign rsp_is_full     = full;
   assign rsp_occupancy   = CAP_W'(count_ff);

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      CMPW'(count_ff) <= DEPTH_C)
      else $error("occupancy above store depth");

   a_fail_no_change: assert property (@(posedge clock) disable iff (reset)
      !reset && cmd.exec && !ok_in |=> $stable(count_ff) && $stable(front_ff))
      else $error("failed request changed the queue");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !reset && !cmd.exec |=> $stable(count_ff) && $stable(front_ff))
      else $error("queue pointers moved outside execution");

endmodule

/* hdl/bounded_double_ended_queue.sv */
// channel    | ports                                         | handshake
// request    | req_kind, req_value                           | start & !busy
// response   | rsp_ok, rsp_front_value, rsp_rear_value,      | rsp_strobe, one cycle
//            | rsp_is_empty, rsp_is_full, rsp_occupancy      |
// capacity   | csr_wdata                                     | csr_we
//
// a request passes in order through execute, store read and response
// the next request may be accepted in the cycle the response is shown
// the pace is set by the registered two-port read of the ring store
// synchronous active-high reset empties the queue and sets capacity to 1024
// the receiver cannot stall; every response is shown for exactly one cycle
module bounded_double_ended_queue #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [bdq_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [bdq_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_strobe,
   output logic                                rsp_ok,
   output logic signed [bdq_pkg::DATA_W-1:0]   rsp_front_value,
   output logic signed [bdq_pkg::DATA_W-1:0]   rsp_rear_value,
   output logic                                rsp_is_empty,
   output logic                                rsp_is_full,
   output logic [bdq_pkg::CAP_W-1:0]           rsp_occupancy,
   input  logic                                csr_we,
   input  logic [bdq_pkg::CAP_W-1:0]           csr_wdata
);
   import bdq_pkg::*;

   cmd_type cmd;

   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   bdq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_kind        (req_kind),
      .req_value       (req_value),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_ok          (rsp_ok),
      .rsp_front_value (rsp_front_value),
      .rsp_rear_value  (rsp_rear_value),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .rsp_occupancy   (rsp_occupancy)
   );

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
   import bdq_pkg::*;

   localparam int DEPTH = DEPTH_DEF;

   localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

   localparam logic signed [DATA_W-1:0] VAL_MIN  = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_MAX  = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] VAL_NONE = -32'sd1;

   typedef struct packed {
      logic                     ok;
      logic signed [DATA_W-1:0] front;
      logic signed [DATA_W-1:0] rear;
      logic                     empty;
      logic                     full;
      logic [CAP_W-1:0]         occ;
   } deque_status_type;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic signed [DATA_W-1:0] value;
      logic                     typed;
      deque_status_type         status;
   } probe_type;

   typedef struct packed {
      logic [CAP_W-1:0] cap;
      logic [11:0]      count;
      logic [6:0]       push_pct;
      logic [6:0]       pop_pct;
      logic             calm;
   } phase_type;

   localparam deque_status_type EMPTY_OK   = '{1'b1, VAL_NONE, VAL_NONE, 1'b1, 1'b0, 11'd0};
   localparam deque_status_type EMPTY_FAIL = '{1'b0, VAL_NONE, VAL_NONE, 1'b1, 1'b0, 11'd0};
   localparam deque_status_type NO_STATUS  = '0;

   // directed requests, capacity at its reset value
   localparam probe_type PROBES [20] = '{
      '{KIND_STATUS,     32'sd0,         1'b1, EMPTY_OK},
      '{KIND_POP_FRONT,  32'sd0,         1'b1, EMPTY_FAIL},
      '{KIND_POP_BACK,   VAL_MAX,        1'b1, EMPTY_FAIL},
      '{KIND_SPARE_A,    VAL_NONE,       1'b1, EMPTY_OK},
      '{KIND_SPARE_B,    VAL_MIN,        1'b1, EMPTY_OK},
      '{KIND_SPARE_C,    VAL_MAX,        1'b1, EMPTY_OK},
      '{KIND_PUSH_BACK,  VAL_MAX,        1'b1, '{1'b1, VAL_MAX, VAL_MAX, 1'b0, 1'b0, 11'd1}},
      // front index wraps below zero here
      '{KIND_PUSH_FRONT, VAL_MIN,        1'b1, '{1'b1, VAL_MIN, VAL_MAX, 1'b0, 1'b0, 11'd2}},
      '{KIND_PUSH_BACK,  VAL_NONE,       1'b0, NO_STATUS},
      '{KIND_PUSH_FRONT, 32'sd0,         1'b0, NO_STATUS},
      '{KIND_PUSH_BACK,  32'sh5555_5555, 1'b0, NO_STATUS},
      '{KIND_PUSH_FRONT, 32'shaaaa_aaaa, 1'b0, NO_STATUS},
      '{KIND_STATUS,     VAL_MIN,        1'b0, NO_STATUS},
      '{KIND_POP_BACK,   32'sd0,         1'b0, NO_STATUS},
      '{KIND_POP_FRONT,  32'sd0,         1'b0, NO_STATUS},
      '{KIND_POP_BACK,   32'sd0,         1'b0, NO_STATUS},
      '{KIND_POP_FRONT,  32'sd0,         1'b0, NO_STATUS},
      '{KIND_POP_FRONT,  32'sd0,         1'b0, NO_STATUS},
      '{KIND_POP_BACK,   32'sd0,         1'b1, EMPTY_OK},
      '{KIND_POP_BACK,   32'sd0,         1'b1, EMPTY_FAIL}
   };

   localparam phase_type PHASES [7] = '{
      '{11'd4,    12'd100,  7'd50, 7'd40, 1'b0},
      '{11'd1,    12'd40,   7'd50, 7'd40, 1'b0},
      '{11'd0,    12'd25,   7'd50, 7'd40, 1'b0},
      '{11'd16,   12'd80,   7'd70, 7'd20, 1'b0},
      // lowered below what is held, mostly drains
      '{11'd2,    12'd50,   7'd25, 7'd65, 1'b0},
      // saturates to the ring depth and fills it
      '{11'd2047, 12'd1080, 7'd98, 7'd1,  1'b0},
      '{11'd3,    12'd60,   7'd40, 7'd40, 1'b1}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [KIND_W-1:0]        req_kind = KIND_STATUS;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_strobe;
   logic                     rsp_ok;
   logic signed [DATA_W-1:0] rsp_front_value;
   logic signed [DATA_W-1:0] rsp_rear_value;
   logic                     rsp_is_empty;
   logic                     rsp_is_full;
   logic [CAP_W-1:0]         rsp_occupancy;
   logic                     csr_we = 1'b0;
   logic [CAP_W-1:0]         csr_wdata = '0;

   // shadow of the queue
   logic signed [DATA_W-1:0] model_ring [DEPTH];
   int                       model_head = 0;
   int                       model_held = 0;
   logic [CAP_W-1:0]         model_cap = CAP_RESET;

   deque_status_type awaited_status [$];

   int requests = 0;
   int refused = 0;
   int checked = 0;
   int mismatches = 0;
   int cap_writes = 0;
   int peak_held = 0;

   bounded_double_ended_queue i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_value       (req_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_ok          (rsp_ok),
      .rsp_front_value (rsp_front_value),
      .rsp_rear_value  (rsp_rear_value),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .rsp_occupancy   (rsp_occupancy),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   always #1 clock = ~clock;

   initial begin
      #400000;
      $display("timeout with %0d responses outstanding", awaited_status.size());
      $display("== FAIL ==");
      $finish;
   end

   function automatic deque_status_type deque_step(input logic [KIND_W-1:0] kind,
                                                   input logic signed [DATA_W-1:0] value);
      deque_status_type st;
      int               lim;
      lim = (int'(model_cap) > DEPTH) ? DEPTH : int'(model_cap);
      st.ok = 1'b1;
      case (kind)
         KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
            if (model_held >= lim) begin
               st.ok = 1'b0;
            end else begin
               if (kind == KIND_PUSH_FRONT) begin
                  model_head = (model_head == 0) ? DEPTH - 1 : model_head - 1;
                  model_ring[model_head] = value;
               end else begin
                  model_ring[(model_head + model_held) % DEPTH] = value;
               end
               model_held++;
            end
         end
         KIND_POP_FRONT, KIND_POP_BACK: begin
            if (model_held == 0) begin
               st.ok = 1'b0;
            end else begin
               if (kind == KIND_POP_FRONT)
                  model_head = (model_head + 1) % DEPTH;
               model_held--;
            end
         end
         default: ;
      endcase
      if (model_held == 0) begin
         st.front = VAL_NONE;
         st.rear  = VAL_NONE;
      end else begin
         st.front = model_ring[model_head];
         st.rear  = model_ring[(model_head + model_held - 1) % DEPTH];
      end
      st.empty = (model_held == 0);
      st.full  = (model_held >= lim);
      st.occ   = CAP_W'(model_held);
      return st;
   endfunction

   function automatic logic [KIND_W-1:0] pick_kind(input int push_pct, input int pop_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < push_pct)
         return $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
      if (r < push_pct + pop_pct)
         return $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
      case ($urandom_range(0, 5))
         0:       return KIND_SPARE_A;
         1:       return KIND_SPARE_B;
         2:       return KIND_SPARE_C;
         default: return KIND_STATUS;
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2:       return VAL_NONE;
         3:       return '0;
         default: return $urandom();
      endcase
   endfunction

   function automatic void note_mismatch(input string why, input deque_status_type exp,
                                         input deque_status_type act);
      if (mismatches < 10) begin
         $display("mismatch at %0t (%s): expected ok=%0b front=%0d rear=%0d", $realtime, why,
                  exp.ok, exp.front, exp.rear, " empty=%0b full=%0b occ=%0d", exp.empty,
                  exp.full, exp.occ);
         $display("   got ok=%0b front=%0d rear=%0d empty=%0b full=%0b occ=%0d",
                  act.ok, act.front, act.rear, act.empty, act.full, act.occ);
      end
      mismatches++;
   endfunction

   task automatic issue_request(input logic [KIND_W-1:0] kind,
                                input logic signed [DATA_W-1:0] value,
                                input logic typed, input deque_status_type typed_status,
                                input logic calm);
      deque_status_type st;
      int               gap;
      gap = 0;
      if (!calm && $urandom_range(0, 4) == 0)
         gap = $urandom_range(1, 15);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_kind  <= kind;
      req_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      st = deque_step(kind, value);
      awaited_status.push_back(typed ? typed_status : st);
      requests++;
      if (!st.ok)
         refused++;
      if (model_held > peak_held)
         peak_held = model_held;
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      while (awaited_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      csr_we    <= 1'b0;
      model_cap = cap;
      cap_writes++;
   endtask

   // responses cannot be held off, so every strobe is taken
   always @(posedge clock) begin
      deque_status_type act;
      deque_status_type exp;
      string            bad;
      if (!reset && rsp_strobe) begin
         act = '{rsp_ok, rsp_front_value, rsp_rear_value, rsp_is_empty, rsp_is_full,
                 rsp_occupancy};
         if (awaited_status.size() == 0) begin
            note_mismatch("no request outstanding", '0, act);
         end else begin
            exp = awaited_status.pop_front();
            bad = "";
            if (act.ok !== exp.ok)       bad = {bad, " ok"};
            if (act.front !== exp.front) bad = {bad, " front"};
            if (act.rear !== exp.rear)   bad = {bad, " rear"};
            if (act.empty !== exp.empty) bad = {bad, " empty"};
            if (act.full !== exp.full)   bad = {bad, " full"};
            if (act.occ !== exp.occ)     bad = {bad, " occupancy"};
            if (bad != "")
               note_mismatch({"field", bad}, exp, act);
            checked++;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (PROBES[i])
         issue_request(PROBES[i].kind, PROBES[i].value, PROBES[i].typed,
                       PROBES[i].status, 1'b0);
      start <= 1'b0;

      foreach (PHASES[p]) begin
         write_capacity(PHASES[p].cap);
         for (int n = 0; n < int'(PHASES[p].count); n++)
            issue_request(pick_kind(int'(PHASES[p].push_pct), int'(PHASES[p].pop_pct)),
                          pick_value(), 1'b0, NO_STATUS, PHASES[p].calm);
         start <= 1'b0;
      end

      while (awaited_status.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d requests over %0d capacity settings, %0d refused as full or empty",
               requests, cap_writes, refused);
      $display("peak occupancy %0d, %0d responses checked, %0d mismatches",
               peak_held, checked, mismatches);
      if (mismatches == 0 && awaited_status.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
